### sv/key_exchange_init_parser_defines.svh
// Assertion macros shared by the key-exchange-init parser RTL.
`ifndef KEY_EXCHANGE_INIT_PARSER_DEFINES_SVH
`define KEY_EXCHANGE_INIT_PARSER_DEFINES_SVH

// Same-cycle property, sampled on clk and disabled while rst_n is low.
`define KEXP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define KEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/kexp_pkg.sv
// Types, codes and constants shared by the key-exchange-init parser.
`timescale 1ns / 1ps

package kexp_pkg;

  // Structure of the key-exchange-init message.
  localparam int NAME_LIST_COUNT = 10;
  localparam int COOKIE_BYTES    = 16;
  localparam logic [7:0] SEPARATOR_BYTE = 8'h2C;

  // Configuration register indexes and reset values.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PACKET_LENGTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_MESSAGE_TYPE = 2'd1;
  localparam logic [31:0] MAX_PACKET_LENGTH_RESET     = 32'd10000000;
  localparam logic [7:0]  EXPECTED_MESSAGE_TYPE_RESET = 8'd20;

  // Result kinds.
  localparam logic [2:0] KIND_HEADER     = 3'd0;
  localparam logic [2:0] KIND_COOKIE     = 3'd1;
  localparam logic [2:0] KIND_NAME_BYTE  = 3'd2;
  localparam logic [2:0] KIND_SEPARATOR  = 3'd3;
  localparam logic [2:0] KIND_EMPTY_LIST = 3'd4;
  localparam logic [2:0] KIND_FOLLOWS    = 3'd5;
  localparam logic [2:0] KIND_DONE       = 3'd6;
  localparam logic [2:0] KIND_ERROR      = 3'd7;

  // Error codes.
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_BAD_PADDING  = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG     = 3'd2;
  localparam logic [2:0] ERR_BAD_MESSAGE  = 3'd3;
  localparam logic [2:0] ERR_TOO_SHORT    = 3'd4;
  localparam logic [2:0] ERR_LIST_OVERRUN = 3'd5;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_LEN    = 4'd0,
    PH_PAD    = 4'd1,
    PH_MSG    = 4'd2,
    PH_COOKIE = 4'd3,
    PH_LLEN   = 4'd4,
    PH_LBODY  = 4'd5,
    PH_FOLLOW = 4'd6,
    PH_SKIP   = 4'd7,
    PH_END    = 4'd8
  } phase_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t      phase;
    logic [4:0]  field_counter;
    logic [31:0] length_shift;
    logic [7:0]  stored_padding;
    logic [31:0] payload_remaining;
    logic [31:0] list_remaining;
    logic [3:0]  current_list;
    logic [7:0]  padding_remaining;
  } kexp_state_t;

  localparam kexp_state_t KEXP_STATE_CLEAR = '{PH_LEN, 5'd0, 32'd0, 8'd0, 32'd0, 32'd0,
                                                4'd0, 8'd0};

  // Fields of one result transaction.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  list_number;
    logic        list_last;
    logic [7:0]  value;
    logic [31:0] packet_length;
    logic [7:0]  padding_length;
    logic [2:0]  error_code;
    logic        packet_last;
  } kexp_result_t;

endpackage

### sv/kexp_step.sv
// Next-state and result logic of the parser for one input byte.
`timescale 1ns / 1ps

module kexp_step import kexp_pkg::*; (
  input  kexp_state_t  st_i,
  input  logic         restart_i,
  input  logic [7:0]   data_i,
  input  logic [31:0]  max_packet_length_i,
  input  logic [7:0]   expected_message_type_i,
  output kexp_state_t  st_nxt_o,
  output logic         res_valid_o,
  output kexp_result_t res_o
);

  kexp_state_t s;
  logic [31:0] ls_shift;
  logic [31:0] pr_dec;
  logic [31:0] lr_dec;
  logic [4:0]  fc_inc;
  logic [3:0]  cl_inc;

  // Error result that ends the packet.
  function automatic kexp_result_t fail_res(input logic [2:0] err, input logic [3:0] list);
    kexp_result_t r;
    r = '0;
    r.kind        = KIND_ERROR;
    r.list_number = list;
    r.error_code  = err;
    r.packet_last = 1'b1;
    return r;
  endfunction

  // A restart byte sees a cleared parser.
  assign s = restart_i ? KEXP_STATE_CLEAR : st_i;

  // Shared arithmetic on the current state.
  assign ls_shift = {s.length_shift[23:0], data_i};
  assign pr_dec   = s.payload_remaining - 32'd1;
  assign lr_dec   = (s.list_remaining != 32'd0) ? s.list_remaining - 32'd1 : 32'd0;
  assign fc_inc   = s.field_counter + 5'd1;
  assign cl_inc   = s.current_list + 4'd1;

  // Phase decode: one byte moves the parser by at most one step.
  always_comb begin
    st_nxt_o    = s;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (s.phase)
      PH_LEN: begin
        st_nxt_o.length_shift = ls_shift;
        if (fc_inc >= 5'd4) begin
          st_nxt_o.field_counter = 5'd0;
          st_nxt_o.phase         = PH_PAD;
        end else begin
          st_nxt_o.field_counter = fc_inc;
        end
      end
      PH_PAD: begin
        st_nxt_o.stored_padding = data_i;
        res_valid_o             = 1'b1;
        res_o.packet_length     = s.length_shift;
        res_o.padding_length    = data_i;
        if ({24'd0, data_i} >= s.length_shift) begin
          st_nxt_o.phase    = PH_END;
          res_o.kind        = KIND_ERROR;
          res_o.error_code  = ERR_BAD_PADDING;
          res_o.packet_last = 1'b1;
        end else if (s.length_shift > max_packet_length_i) begin
          st_nxt_o.phase    = PH_END;
          res_o.kind        = KIND_ERROR;
          res_o.error_code  = ERR_TOO_LONG;
          res_o.packet_last = 1'b1;
        end else begin
          st_nxt_o.payload_remaining = s.length_shift - {24'd0, data_i} - 32'd1;
          st_nxt_o.padding_remaining = data_i;
          st_nxt_o.phase             = PH_MSG;
          res_o.kind                 = KIND_HEADER;
        end
      end
      PH_MSG: begin
        if (s.payload_remaining == 32'd0) begin
          st_nxt_o.phase = PH_END;
          res_valid_o    = 1'b1;
          res_o          = fail_res(ERR_TOO_SHORT, 4'd0);
        end else if (data_i != expected_message_type_i) begin
          st_nxt_o.phase = PH_END;
          res_valid_o    = 1'b1;
          res_o          = fail_res(ERR_BAD_MESSAGE, 4'd0);
        end else begin
          st_nxt_o.payload_remaining = pr_dec;
          if (pr_dec < 32'(COOKIE_BYTES)) begin
            st_nxt_o.phase = PH_END;
            res_valid_o    = 1'b1;
            res_o          = fail_res(ERR_TOO_SHORT, 4'd0);
          end else begin
            st_nxt_o.field_counter = 5'd0;
            st_nxt_o.phase         = PH_COOKIE;
          end
        end
      end
      PH_COOKIE: begin
        st_nxt_o.payload_remaining = pr_dec;
        st_nxt_o.field_counter     = fc_inc;
        if (fc_inc >= 5'(COOKIE_BYTES)) begin
          st_nxt_o.current_list  = 4'd0;
          st_nxt_o.field_counter = 5'd0;
          st_nxt_o.length_shift  = 32'd0;
          st_nxt_o.phase         = (NAME_LIST_COUNT > 0) ? PH_LLEN : PH_FOLLOW;
        end
        res_valid_o = 1'b1;
        res_o.kind  = KIND_COOKIE;
        res_o.value = data_i;
      end
      PH_LLEN: begin
        if (s.field_counter == 5'd0 && s.payload_remaining < 32'd4) begin
          st_nxt_o.phase = PH_END;
          res_valid_o    = 1'b1;
          res_o          = fail_res(ERR_TOO_SHORT, 4'd0);
        end else begin
          st_nxt_o.length_shift      = ls_shift;
          st_nxt_o.payload_remaining = pr_dec;
          if (fc_inc < 5'd4) begin
            st_nxt_o.field_counter = fc_inc;
          end else begin
            st_nxt_o.field_counter = 5'd0;
            if (ls_shift > pr_dec) begin
              st_nxt_o.phase = PH_END;
              res_valid_o    = 1'b1;
              res_o          = fail_res(ERR_LIST_OVERRUN, s.current_list);
            end else if (ls_shift == 32'd0) begin
              // Empty list: report it and move on to the next list.
              st_nxt_o.current_list = cl_inc;
              st_nxt_o.length_shift = 32'd0;
              st_nxt_o.phase = (cl_inc >= 4'(NAME_LIST_COUNT)) ? PH_FOLLOW : PH_LLEN;
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_EMPTY_LIST;
              res_o.list_number = s.current_list;
              res_o.list_last   = 1'b1;
            end else begin
              st_nxt_o.list_remaining = ls_shift;
              st_nxt_o.phase          = PH_LBODY;
            end
          end
        end
      end
      PH_LBODY: begin
        if (s.payload_remaining != 32'd0) begin
          st_nxt_o.payload_remaining = pr_dec;
        end
        st_nxt_o.list_remaining = lr_dec;
        if (lr_dec == 32'd0) begin
          st_nxt_o.current_list  = cl_inc;
          st_nxt_o.length_shift  = 32'd0;
          st_nxt_o.field_counter = 5'd0;
          st_nxt_o.phase = (cl_inc >= 4'(NAME_LIST_COUNT)) ? PH_FOLLOW : PH_LLEN;
        end
        res_valid_o       = 1'b1;
        res_o.kind        = (data_i == SEPARATOR_BYTE) ? KIND_SEPARATOR : KIND_NAME_BYTE;
        res_o.list_number = s.current_list;
        res_o.list_last   = (lr_dec == 32'd0);
        res_o.value       = data_i;
      end
      PH_FOLLOW: begin
        res_valid_o = 1'b1;
        if (s.payload_remaining == 32'd0) begin
          st_nxt_o.phase = PH_END;
          res_o          = fail_res(ERR_TOO_SHORT, 4'd0);
        end else begin
          st_nxt_o.payload_remaining = pr_dec;
          res_o.kind                 = KIND_FOLLOWS;
          res_o.value                = data_i;
          if (pr_dec == 32'd0 && s.padding_remaining == 8'd0) begin
            st_nxt_o.phase    = PH_END;
            res_o.packet_last = 1'b1;
          end else begin
            st_nxt_o.phase = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        // Rest of the payload first, then the padding.
        if (s.payload_remaining != 32'd0) begin
          st_nxt_o.payload_remaining = pr_dec;
        end else if (s.padding_remaining != 8'd0) begin
          st_nxt_o.padding_remaining = s.padding_remaining - 8'd1;
        end
        if (st_nxt_o.payload_remaining == 32'd0 && st_nxt_o.padding_remaining == 8'd0) begin
          st_nxt_o.phase    = PH_END;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_DONE;
          res_o.packet_last = 1'b1;
        end
      end
      default: begin
        // Packet finished or failed: bytes are dropped until restart.
      end
    endcase
  end

endmodule

### sv/key_exchange_init_parser.sv
// Top level of the key-exchange-init packet parser.
`timescale 1ns / 1ps
`include "key_exchange_init_parser_defines.svh"

// The parser takes one byte of a secure-shell binary packet per clock cycle and
// gives at most one result per byte, in the cycle after the byte is accepted, from a
// single result register. Bytes are accepted back to back at one per cycle; the
// input stalls only while that result register holds a result and out_stall is
// high. A byte with in_restart high starts a new packet and is its first length
// byte. After an error or the end of the packet, bytes give no result until the
// next restart. The configuration port always accepts writes (cfg_ready is high);
// index 0 is the maximum packet length and index 1 the expected message type, and
// writes are expected only while the parser is idle. There is no clearing pass
// after reset.

module key_exchange_init_parser import kexp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Byte input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_restart,
  input  logic [7:0]             in_data_byte,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_kind,
  output logic [3:0]             out_list_number,
  output logic                   out_list_last,
  output logic [7:0]             out_value,
  output logic [31:0]            out_packet_length,
  output logic [7:0]             out_padding_length,
  output logic [2:0]             out_error_code,
  output logic                   out_packet_last,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  logic         in_acc;
  logic         out_take;
  logic         cfg_acc;
  logic [31:0]  max_packet_length_r;
  logic [7:0]   expected_message_type_r;
  kexp_state_t  st_r;
  kexp_state_t  st_nxt;
  logic         res_valid;
  kexp_result_t res;
  kexp_result_t res_r;
  logic         out_valid_r;
  logic         out_valid_nxt;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_take  = out_valid_r & ~out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_packet_length_r     <= MAX_PACKET_LENGTH_RESET;
      expected_message_type_r <= EXPECTED_MESSAGE_TYPE_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        CFG_MAX_PACKET_LENGTH:     max_packet_length_r     <= cfg_data;
        CFG_EXPECTED_MESSAGE_TYPE: expected_message_type_r <= cfg_data[7:0];
        default: begin
          // Writes beyond the register list are ignored.
        end
      endcase
    end
  end

  // Per-byte parsing logic.
  kexp_step u_step (
    .st_i                    (st_r),
    .restart_i               (in_restart),
    .data_i                  (in_data_byte),
    .max_packet_length_i     (max_packet_length_r),
    .expected_message_type_i (expected_message_type_r),
    .st_nxt_o                (st_nxt),
    .res_valid_o             (res_valid),
    .res_o                   (res)
  );

  // Parser state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= KEXP_STATE_CLEAR;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // Result register: loaded by a byte that gives a result, emptied when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = res_r.kind;
  assign out_list_number    = res_r.list_number;
  assign out_list_last      = res_r.list_last;
  assign out_value          = res_r.value;
  assign out_packet_length  = res_r.packet_length;
  assign out_padding_length = res_r.padding_length;
  assign out_error_code     = res_r.error_code;
  assign out_packet_last    = res_r.packet_last;

  // Checks on the parser's own behavior.
  `KEXP_ASSERT(a_error_ends_packet, (out_valid_r && res_r.kind == KIND_ERROR) |-> res_r.packet_last, "error result without packet_last")
  `KEXP_ASSERT(a_code_only_on_error, (out_valid_r && res_r.kind != KIND_ERROR) |-> (res_r.error_code == ERR_NONE), "error code on a non-error result")
  `KEXP_ASSERT(a_header_then_message, (out_valid_r && res_r.kind == KIND_HEADER) |-> (st_r.phase == PH_MSG), "header result shown while parser is not at the message byte")
  `KEXP_ASSERT_NEXT(a_end_holds, in_acc && !in_restart && st_r.phase == PH_END, st_r.phase == PH_END, "parser left the end phase without restart")

endmodule

### tb/tb_key_exchange_init_parser.sv
// Self-checking testbench for the key-exchange-init packet parser.
`timescale 1ns / 1ps

module tb_key_exchange_init_parser;
  import kexp_pkg::*;

  // Stimulus packet shapes.
  localparam int PKT_GOOD     = 0;
  localparam int PKT_CUT      = 1;
  localparam int PKT_ABORT    = 2;
  localparam int PKT_BAD_PAD  = 3;
  localparam int PKT_TOO_LONG = 4;
  localparam int PKT_BAD_MSG  = 5;
  localparam int PKT_NOISE    = 6;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } byte_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_restart = 1'b0;
  logic [7:0]             in_data_byte = 8'd0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [2:0]             out_kind;
  logic [3:0]             out_list_number;
  logic                   out_list_last;
  logic [7:0]             out_value;
  logic [31:0]            out_packet_length;
  logic [7:0]             out_padding_length;
  logic [2:0]             out_error_code;
  logic                   out_packet_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = 32'd0;

  // Bytes waiting to be driven and results predicted but not yet seen.
  byte_item_t   byte_backlog[$];
  kexp_result_t predicted_results[$];
  int           items_queued = 0;
  int           mismatches = 0;
  int           cycle_count = 0;
  logic         in_taken = 1'b0;
  logic         cfg_taken = 1'b0;
  int           in_gap = 0;
  bit           in_quiet = 1'b0;
  bit           out_quiet = 1'b0;
  int           out_hold = 0;

  // Predictor copy of the configuration and the parser state.
  logic [31:0] cfg_max_len;
  logic [7:0]  cfg_msg_type;
  phase_t      ph;
  logic [4:0]  cnt;
  logic [31:0] len_acc;
  logic [7:0]  pad_len;
  logic [31:0] payload_left;
  logic [31:0] list_left;
  logic [3:0]  list_idx;
  logic [7:0]  pad_left;

  key_exchange_init_parser u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_list_number    (out_list_number),
    .out_list_last      (out_list_last),
    .out_value          (out_value),
    .out_packet_length  (out_packet_length),
    .out_padding_length (out_padding_length),
    .out_error_code     (out_error_code),
    .out_packet_last    (out_packet_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Put the predicted parser back into the length phase with empty counters.
  function automatic void clear_parse_state();
    ph           = PH_LEN;
    cnt          = 5'd0;
    len_acc      = 32'd0;
    pad_len      = 8'd0;
    payload_left = 32'd0;
    list_left    = 32'd0;
    list_idx     = 4'd0;
    pad_left     = 8'd0;
  endfunction

  // Step to the next name-list, or to the follows flag after the last one.
  function automatic void advance_list();
    list_idx = list_idx + 4'd1;
    len_acc  = 32'd0;
    cnt      = 5'd0;
    ph       = (list_idx >= NAME_LIST_COUNT) ? PH_FOLLOW : PH_LLEN;
  endfunction

  // An error ends the packet with a single error result.
  function automatic bit end_with_error(input logic [2:0] code, input logic [3:0] list,
                                        output kexp_result_t r);
    r             = '0;
    r.kind        = KIND_ERROR;
    r.list_number = list;
    r.error_code  = code;
    r.packet_last = 1'b1;
    ph            = PH_END;
    return 1'b1;
  endfunction

  // Predict the result, if any, of one accepted byte.
  function automatic bit parse_byte(input logic restart, input logic [7:0] b,
                                    output kexp_result_t r);
    logic [3:0] n;
    logic       last;
    r = '0;
    if (restart) clear_parse_state();
    case (ph)
      PH_LEN: begin
        len_acc = {len_acc[23:0], b};
        cnt = cnt + 5'd1;
        if (cnt >= 5'd4) begin
          cnt = 5'd0;
          ph  = PH_PAD;
        end
        return 1'b0;
      end
      PH_PAD: begin
        pad_len = b;
        r.packet_length  = len_acc;
        r.padding_length = b;
        if (32'(b) >= len_acc) begin
          ph = PH_END;
          r.kind = KIND_ERROR;
          r.error_code = ERR_BAD_PADDING;
          r.packet_last = 1'b1;
          return 1'b1;
        end
        if (len_acc > cfg_max_len) begin
          ph = PH_END;
          r.kind = KIND_ERROR;
          r.error_code = ERR_TOO_LONG;
          r.packet_last = 1'b1;
          return 1'b1;
        end
        payload_left = len_acc - 32'(pad_len) - 32'd1;
        pad_left = pad_len;
        ph = PH_MSG;
        r.kind = KIND_HEADER;
        return 1'b1;
      end
      PH_MSG: begin
        if (payload_left == 32'd0) return end_with_error(ERR_TOO_SHORT, 4'd0, r);
        if (b != cfg_msg_type) return end_with_error(ERR_BAD_MESSAGE, 4'd0, r);
        payload_left = payload_left - 32'd1;
        if (payload_left < COOKIE_BYTES) return end_with_error(ERR_TOO_SHORT, 4'd0, r);
        cnt = 5'd0;
        ph  = PH_COOKIE;
        return 1'b0;
      end
      PH_COOKIE: begin
        payload_left = payload_left - 32'd1;
        cnt = cnt + 5'd1;
        if (cnt >= COOKIE_BYTES) begin
          list_idx = 4'd0;
          cnt      = 5'd0;
          len_acc  = 32'd0;
          ph       = (NAME_LIST_COUNT > 0) ? PH_LLEN : PH_FOLLOW;
        end
        r.kind  = KIND_COOKIE;
        r.value = b;
        return 1'b1;
      end
      PH_LLEN: begin
        if (cnt == 5'd0 && payload_left < 32'd4)
          return end_with_error(ERR_TOO_SHORT, 4'd0, r);
        len_acc = {len_acc[23:0], b};
        payload_left = payload_left - 32'd1;
        cnt = cnt + 5'd1;
        if (cnt < 5'd4) return 1'b0;
        cnt = 5'd0;
        if (len_acc > payload_left) return end_with_error(ERR_LIST_OVERRUN, list_idx, r);
        if (len_acc == 32'd0) begin
          n = list_idx;
          advance_list();
          r.kind = KIND_EMPTY_LIST;
          r.list_number = n;
          r.list_last = 1'b1;
          return 1'b1;
        end
        list_left = len_acc;
        ph = PH_LBODY;
        return 1'b0;
      end
      PH_LBODY: begin
        n = list_idx;
        if (payload_left > 32'd0) payload_left = payload_left - 32'd1;
        if (list_left > 32'd0) list_left = list_left - 32'd1;
        last = (list_left == 32'd0);
        if (last) advance_list();
        r.kind = (b == SEPARATOR_BYTE) ? KIND_SEPARATOR : KIND_NAME_BYTE;
        r.list_number = n;
        r.list_last = last;
        r.value = b;
        return 1'b1;
      end
      PH_FOLLOW: begin
        if (payload_left == 32'd0) return end_with_error(ERR_TOO_SHORT, 4'd0, r);
        payload_left = payload_left - 32'd1;
        r.kind  = KIND_FOLLOWS;
        r.value = b;
        if (payload_left == 32'd0 && pad_left == 8'd0) begin
          ph = PH_END;
          r.packet_last = 1'b1;
        end else begin
          ph = PH_SKIP;
        end
        return 1'b1;
      end
      PH_SKIP: begin
        if (payload_left > 32'd0) payload_left = payload_left - 32'd1;
        else if (pad_left > 8'd0) pad_left = pad_left - 8'd1;
        if (payload_left == 32'd0 && pad_left == 8'd0) begin
          ph = PH_END;
          r.kind = KIND_DONE;
          r.packet_last = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int idle_len(input bit quiet);
    int r;
    r = int'($urandom_range(0, 99));
    if (quiet || r < 60) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  task automatic push_item(input logic restart, input logic [7:0] data);
    byte_backlog.push_back('{restart, data});
    items_queued++;
  endtask

  // Four big-endian length bytes, the first one restarting the parser, then padding.
  task automatic send_header(input logic [31:0] len, input logic [7:0] pad);
    push_item(1'b1, len[31:24]);
    push_item(1'b0, len[23:16]);
    push_item(1'b0, len[15:8]);
    push_item(1'b0, len[7:0]);
    push_item(1'b0, pad);
  endtask

  // Build one packet with random content and queue its bytes.
  task automatic queue_packet(input int variant, input int max_list, input bit tight,
                              input int cut);
    logic [7:0]  body[$];
    logic [31:0] plen;
    logic [31:0] llen;
    logic [7:0]  c;
    logic [7:0]  msg;
    int          pad;
    int          extra;
    int          stop;
    if (variant == PKT_NOISE) begin
      repeat ($urandom_range(3, 20)) push_item($urandom_range(0, 9) == 0, 8'($urandom));
      return;
    end
    msg = cfg_msg_type;
    if (variant == PKT_BAD_MSG) msg = cfg_msg_type ^ 8'($urandom_range(1, 255));
    body.push_back(msg);
    repeat (COOKIE_BYTES) body.push_back(8'($urandom));
    for (int l = 0; l < NAME_LIST_COUNT; l++) begin
      llen = (max_list == 0 || $urandom_range(0, 4) == 0) ? 32'd0 :
             32'($urandom_range(1, max_list));
      for (int k = 3; k >= 0; k--) body.push_back(llen[8*k +: 8]);
      repeat (llen) begin
        if ($urandom_range(0, 5) == 0) c = SEPARATOR_BYTE;
        else if ($urandom_range(0, 3) == 0) c = 8'($urandom);
        else c = 8'($urandom_range(8'h61, 8'h7a));
        body.push_back(c);
      end
    end
    body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)));
    extra = tight ? 0 : int'($urandom_range(0, 3));
    repeat (extra) body.push_back(8'($urandom));
    if (tight || $urandom_range(0, 3) == 0) pad = 0;
    else pad = int'($urandom_range(1, ($urandom_range(0, 15) == 0) ? 255 : 12));
    plen = 32'(body.size() + pad + 1);
    stop = body.size() + pad;

    // Bend the well-formed packet into the requested broken shape.
    case (variant)
      PKT_CUT: begin
        plen = 32'(((cut >= 0) ? cut : int'($urandom_range(0, body.size() - 1))) + pad + 1);
      end
      PKT_ABORT: begin
        plen = plen + 32'($urandom_range(1, 1000));
        if ($urandom_range(0, 1) == 1 && cfg_max_len > plen)
          plen = $urandom_range(plen, cfg_max_len);
        stop = int'($urandom_range(0, body.size() + pad));
      end
      PKT_BAD_PAD: begin
        plen = 32'($urandom_range(0, 255));
        pad  = int'($urandom_range(plen, 255));
        stop = int'($urandom_range(0, 3));
      end
      PKT_TOO_LONG: begin
        if (cfg_max_len != 32'hFFFF_FFFF) begin
          plen = $urandom_range(32'hFFFF_FFFF, cfg_max_len + 32'd1);
          stop = int'($urandom_range(0, 3));
        end
      end
      default: ;
    endcase

    send_header(plen, 8'(pad));
    for (int i = 0; i < stop; i++)
      push_item(1'b0, (i < body.size()) ? body[i] : 8'($urandom));
    // Stray bytes after the end of a packet are not counted in items_queued.
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 5)) byte_backlog.push_back('{1'b0, 8'($urandom)});
  endtask

  // Wait until all bytes are in and every predicted result has arrived.
  task automatic wait_drained();
    while (byte_backlog.size() != 0 || in_valid || predicted_results.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // Reconfigure once idle, then queue random packets for this setting.
  task automatic run_phase(input logic [31:0] max_len, input logic [7:0] msg_type,
                           input int target);
    int base;
    int r;
    wait_drained();
    write_reg(CFG_MAX_PACKET_LENGTH, max_len);
    write_reg(CFG_EXPECTED_MESSAGE_TYPE, {24'd0, msg_type});
    @(posedge clk);
    #1;
    base = items_queued;
    while (items_queued - base < target) begin
      r = int'($urandom_range(0, 99));
      queue_packet((r < 64) ? PKT_GOOD : (r < 74) ? PKT_CUT : (r < 81) ? PKT_ABORT :
                   (r < 85) ? PKT_BAD_PAD : (r < 89) ? PKT_TOO_LONG :
                   (r < 93) ? PKT_BAD_MSG : PKT_NOISE,
                   ($urandom_range(0, 7) == 0) ? 20 : 5,
                   $urandom_range(0, 5) == 0, -1);
    end
  endtask

  // Byte driver: a new transaction once the previous one is taken.
  always @(negedge clk) begin : drive_bytes
    byte_item_t nx;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_backlog.size() > 0) begin
        nx = byte_backlog.pop_front();
        in_restart   <= nx.restart;
        in_data_byte <= nx.data;
        in_valid     <= 1'b1;
        in_gap       <= idle_len(in_quiet);
        if ($urandom_range(0, 49) == 0) in_quiet <= !in_quiet;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure: stall runs separated by ready cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_hold > 0) begin
        out_hold = out_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_hold = idle_len(out_quiet);
        out_stall <= 1'b0;
        if ($urandom_range(0, 49) == 0) out_quiet = !out_quiet;
      end
    end
  end

  // Monitor: predict on each input transaction, check each result transaction.
  always @(posedge clk) begin : watch_ports
    kexp_result_t got;
    kexp_result_t want;
    kexp_result_t fresh;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      cfg_taken <= 1'b0;
      cfg_max_len  = MAX_PACKET_LENGTH_RESET;
      cfg_msg_type = EXPECTED_MESSAGE_TYPE_RESET;
      clear_parse_state();
    end else begin
      in_taken  <= in_valid && !in_stall;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_PACKET_LENGTH:     cfg_max_len = cfg_data;
          CFG_EXPECTED_MESSAGE_TYPE: cfg_msg_type = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(in_restart, in_data_byte, fresh)) predicted_results.push_back(fresh);
      end
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_list_number, out_list_last, out_value, out_packet_length,
                out_padding_length, out_error_code, out_packet_last};
        if (predicted_results.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected result: kind=%0d list=%0d err=%0d", got.kind,
                     got.list_number, got.error_code);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_MAX)
              $display({"result mismatch: expected kind=%0d list=%0d last=%0b val=%02h ",
                        "len=%08h pad=%02h err=%0d plast=%0b, got kind=%0d list=%0d ",
                        "last=%0b val=%02h len=%08h pad=%02h err=%0d plast=%0b"},
                       want.kind, want.list_number, want.list_last, want.value,
                       want.packet_length, want.padding_length, want.error_code,
                       want.packet_last, got.kind, got.list_number, got.list_last,
                       got.value, got.packet_length, got.padding_length,
                       got.error_code, got.packet_last);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    #1;

    // Header corner cases: zero length, padding equal to length, too long,
    // length exactly at the limit with a wrong message, empty payload, short cookie.
    send_header(32'd0, 8'd0);
    send_header(32'd5, 8'd5);
    send_header(32'hFFFF_FFFF, 8'd0);
    send_header(MAX_PACKET_LENGTH_RESET, 8'd255);
    push_item(1'b0, ~EXPECTED_MESSAGE_TYPE_RESET);
    send_header(32'd1, 8'd0);
    push_item(1'b0, EXPECTED_MESSAGE_TYPE_RESET);
    send_header(32'd10, 8'd0);
    push_item(1'b0, EXPECTED_MESSAGE_TYPE_RESET);
    push_item(1'b0, 8'hFF);
    // All lists empty with nothing to skip, a list length with too few bytes left,
    // and a packet that ends right before the follows flag.
    queue_packet(PKT_GOOD, 0, 1'b1, -1);
    queue_packet(PKT_CUT, 0, 1'b1, 1 + COOKIE_BYTES + 2);
    queue_packet(PKT_CUT, 0, 1'b1, 1 + COOKIE_BYTES + 4 * NAME_LIST_COUNT);

    run_phase(32'hFFFF_FFFF, 8'd0, 320);
    run_phase(32'd0, 8'd255, 40);
    run_phase(32'($urandom_range(60, 120)), 8'($urandom), 280);
    run_phase(MAX_PACKET_LENGTH_RESET, EXPECTED_MESSAGE_TYPE_RESET, 440);
    wait_drained();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/kexp_pkg.sv
sv/kexp_step.sv
sv/key_exchange_init_parser.sv
tb/tb_key_exchange_init_parser.sv
